// ===== sv/assert_macros.svh =====
// Assertion macros for the module that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk outside reset.
`define NGSW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never hold at a rising edge of clk outside reset.
`define NGSW_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== sv/ngsw_pkg.sv =====
// Package with the shared types, codes and defaults of the successor walk block.
package ngsw_pkg;

	// Default sizes of the row table.
	localparam int ROW_LENGTH_DEF = 32;
	localparam int TABLE_ROWS_DEF = 256;

	// Depths of the command queue and the result queue.
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 4;

	// Configuration register indexes.
	localparam logic CFG_VECTOR_LENGTH = 1'b0;
	localparam logic CFG_START_ROW     = 1'b1;

	// Operation codes of an input request.
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_START = 2'd1,
		OP_STEP  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// One classified command handed from the front to the back.
	typedef struct packed {
		op_t               op;
		logic signed [7:0] value;
	} cmd_t;

	// One result element.
	typedef struct packed {
		logic signed [7:0] value;
		logic [7:0]        row;
		logic              last;
		logic              status;
	} res_t;

endpackage

// ===== sv/ngram_successor_walk.sv =====
// Top level of the successor walk block: configuration, front, back and result queue.
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------------
//  input    | push / full      | operation, element_value
//  result   | pop / empty      | value_out, row_index, last_of_row, status
//  config   | cfg_valid/ready  | cfg_index, cfg_data
//
// A load writes one element while the back end stays idle. A start emits its
// row element by element, each via a read and a write state, as the row table
// read is registered. A step compares candidates element by element, drops
// one at its first mismatch, then emits the successor row the same way.
// Reset clears the counters and queues; the row table is not cleared.
// A full result queue stalls the back end; the command queue stalls the input.
module ngram_successor_walk #(
	parameter int ROW_LENGTH = ngsw_pkg::ROW_LENGTH_DEF,
	parameter int TABLE_ROWS = ngsw_pkg::TABLE_ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        operation,
	input  logic signed [7:0] element_value,
	output logic              empty,
	input  logic              pop,
	output logic signed [7:0] value_out,
	output logic [7:0]        row_index,
	output logic              last_of_row,
	output logic              status,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data
);
	logic [5:0]     vector_length_q;
	logic [7:0]     start_row_q;
	logic           cmd_valid;
	ngsw_pkg::cmd_t cmd;
	logic           cmd_pop;
	logic           res_valid;
	logic           res_ready;
	ngsw_pkg::res_t res;
	ngsw_pkg::res_t res_head;
	logic           rq_full;

	// Configuration registers take a write in any cycle.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_length_q <= 6'd32;
			start_row_q     <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ngsw_pkg::CFG_VECTOR_LENGTH: vector_length_q <= cfg_data[5:0];
				ngsw_pkg::CFG_START_ROW:     start_row_q     <= cfg_data;
			endcase
		end
	end

	ngsw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.operation    (operation),
		.element_value(element_value),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	ngsw_back #(
		.ROW_LENGTH(ROW_LENGTH),
		.TABLE_ROWS(TABLE_ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.vector_length(vector_length_q),
		.start_row    (start_row_q),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res)
	);

	// Result queue decouples emission from the consumer.
	assign res_ready = !rq_full;
	ngsw_fifo #(
		.WIDTH($bits(ngsw_pkg::res_t)),
		.DEPTH(ngsw_pkg::RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_valid),
		.wr_data(res),
		.full   (rq_full),
		.rd_en  (pop),
		.rd_data(res_head),
		.empty  (empty)
	);

	assign value_out   = res_head.value;
	assign row_index   = res_head.row;
	assign last_of_row = res_head.last;
	assign status      = res_head.status;

`include "assert_macros.svh"

	// An error result is a single zero element that closes its row.
	`NGSW_ASSERT(a_err_shape, (!empty && status) |-> (last_of_row && value_out == 8'sd0 && row_index == 8'd0), "error result malformed")
	// The back end takes a command only when one is queued.
	`NGSW_NEVER(a_pop_empty, cmd_pop && !cmd_valid, "command taken from empty queue")
	// A result is offered while the back end is not idle.
	`NGSW_NEVER(a_res_pop, res_valid && cmd_pop, "result offered while taking a command")

endmodule

// ===== sv/ngsw_fifo.sv =====
// Small synchronous queue built from flip-flops.
module ngsw_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots carry payload only.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== sv/ngsw_front.sv =====
// Front end: accepts input requests, drops unused codes and queues commands.
module ngsw_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         operation,
	input  logic signed [7:0]  element_value,
	output logic               cmd_valid,
	output ngsw_pkg::cmd_t     cmd,
	input  logic               cmd_pop
);
	ngsw_pkg::cmd_t cmd_in;
	logic           q_full;
	logic           q_empty;
	logic           q_wr;

	// Classify the request; the unused code is accepted and discarded.
	always_comb begin
		cmd_in.op    = ngsw_pkg::op_t'(operation);
		cmd_in.value = element_value;
	end

	assign full      = q_full;
	assign q_wr      = push && !q_full && (cmd_in.op != ngsw_pkg::OP_NONE);
	assign cmd_valid = !q_empty;

	ngsw_fifo #(
		.WIDTH($bits(ngsw_pkg::cmd_t)),
		.DEPTH(ngsw_pkg::CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_wr),
		.wr_data(cmd_in),
		.full   (q_full),
		.rd_en  (cmd_pop),
		.rd_data(cmd),
		.empty  (q_empty)
	);

endmodule

// ===== sv/ngsw_back.sv =====
// Back end: owns the row table, runs loads, the successor search and row emission.
module ngsw_back #(
	parameter int ROW_LENGTH = ngsw_pkg::ROW_LENGTH_DEF,
	parameter int TABLE_ROWS = ngsw_pkg::TABLE_ROWS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  ngsw_pkg::cmd_t cmd,
	output logic           cmd_pop,
	input  logic [5:0]     vector_length,
	input  logic [7:0]     start_row,
	output logic           res_valid,
	input  logic           res_ready,
	output ngsw_pkg::res_t res
);
	localparam int CW   = (ROW_LENGTH > 1) ? $clog2(ROW_LENGTH) : 1;
	localparam int RW   = $clog2(TABLE_ROWS);
	localparam int MAW  = RW + CW;
	localparam int CMPW = (RW + 1 > 8) ? RW + 1 : 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP_RD,
		S_CMP_CHK,
		S_EMIT_RD,
		S_EMIT_WR,
		S_ERR
	} state_t;

	state_t            state_q;
	logic [RW:0]       loaded_q;
	logic [CW-1:0]     fill_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     cur_q;
	logic [RW-1:0]     cand_q;
	logic [RW-1:0]     row_q;

	logic [7:0]        mem_q [(TABLE_ROWS << CW)];
	logic [7:0]        rd_a_q;
	logic [7:0]        rd_b_q;
	logic [MAW-1:0]    addr_a;
	logic [MAW-1:0]    addr_b;
	logic [MAW-1:0]    addr_w;
	logic              mem_we;

	logic [6:0]        eff_len;
	logic [CW-1:0]     last_col;
	logic              table_full;
	logic [RW-1:0]     cur_wrap;
	logic [RW-1:0]     cand_wrap;

	// Effective row length: zero acts as one, anything longer is clamped.
	always_comb begin
		if (vector_length == 6'd0) begin
			eff_len = 7'd1;
		end else if ({1'b0, vector_length} > 7'(ROW_LENGTH)) begin
			eff_len = 7'(ROW_LENGTH);
		end else begin
			eff_len = {1'b0, vector_length};
		end
		last_col = CW'(eff_len - 7'd1);
	end

	// Next row after a given one, wrapping at the loaded count.
	assign cur_wrap   = (({1'b0, cur_q} + 1'b1) >= loaded_q) ? '0 : cur_q + 1'b1;
	assign cand_wrap  = (({1'b0, cand_q} + 1'b1) >= loaded_q) ? '0 : cand_q + 1'b1;
	assign table_full = (loaded_q == (RW+1)'(TABLE_ROWS));

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;
	assign mem_we  = cmd_pop && (cmd.op == ngsw_pkg::OP_LOAD) && !table_full;
	assign addr_w  = {loaded_q[RW-1:0], fill_q};
	assign addr_a  = ((state_q == S_EMIT_RD) || (state_q == S_EMIT_WR)) ?
		{row_q, col_q} : {cand_q, col_q};
	assign addr_b  = {cur_q, col_q};

	// Row table: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[addr_w] <= cmd.value;
		end
		rd_a_q <= mem_q[addr_a];
		rd_b_q <= mem_q[addr_b];
	end

	// Result payload.
	assign res_valid = (state_q == S_EMIT_WR) || (state_q == S_ERR);
	always_comb begin
		if (state_q == S_ERR) begin
			res.value  = '0;
			res.row    = '0;
			res.last   = 1'b1;
			res.status = 1'b1;
		end else begin
			res.value  = rd_a_q;
			res.row    = 8'(row_q);
			res.last   = (col_q == last_col);
			res.status = 1'b0;
		end
	end

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			loaded_q <= '0;
			fill_q   <= '0;
			col_q    <= '0;
			cur_q    <= '0;
			cand_q   <= '0;
			row_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.op)
							ngsw_pkg::OP_LOAD: begin
								if (!table_full) begin
									if (fill_q >= last_col) begin
										fill_q   <= '0;
										loaded_q <= loaded_q + 1'b1;
									end else begin
										fill_q <= fill_q + 1'b1;
									end
								end
							end
							ngsw_pkg::OP_START: begin
								if ((loaded_q == '0) ||
									(CMPW'(start_row) >= CMPW'(loaded_q))) begin
									state_q <= S_ERR;
								end else begin
									cur_q   <= RW'(start_row);
									row_q   <= RW'(start_row);
									col_q   <= '0;
									state_q <= S_EMIT_RD;
								end
							end
							ngsw_pkg::OP_STEP: begin
								if (loaded_q == '0) begin
									state_q <= S_ERR;
								end else begin
									cand_q  <= cur_wrap;
									col_q   <= '0;
									state_q <= S_CMP_RD;
								end
							end
							ngsw_pkg::OP_NONE: begin
							end
						endcase
					end
				end
				S_CMP_RD: begin
					// The current row always matches itself.
					if (cand_q == cur_q) begin
						row_q   <= cand_wrap;
						cur_q   <= cand_wrap;
						col_q   <= '0;
						state_q <= S_EMIT_RD;
					end else begin
						state_q <= S_CMP_CHK;
					end
				end
				S_CMP_CHK: begin
					if (rd_a_q != rd_b_q) begin
						cand_q  <= cand_wrap;
						col_q   <= '0;
						state_q <= S_CMP_RD;
					end else if (col_q == last_col) begin
						row_q   <= cand_wrap;
						cur_q   <= cand_wrap;
						col_q   <= '0;
						state_q <= S_EMIT_RD;
					end else begin
						col_q   <= col_q + 1'b1;
						state_q <= S_CMP_RD;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_WR;
				end
				S_EMIT_WR: begin
					if (res_ready) begin
						if (col_q == last_col) begin
							state_q <= S_IDLE;
						end else begin
							col_q   <= col_q + 1'b1;
							state_q <= S_EMIT_RD;
						end
					end
				end
				S_ERR: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
